[src/descending_sorted_key_table_macros.svh]
// ----------------------------------------------------------------------------
// Descending sorted key table: assertion macros
// Clocked on clk_i and disabled while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DESCENDING_SORTED_KEY_TABLE_MACROS_SVH
`define DESCENDING_SORTED_KEY_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// plain property on every clock edge
`define DSKT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dskt: assertion failed");

// same-cycle implication
`define DSKT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dskt: implication failed");

// next-cycle implication
`define DSKT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dskt: next-cycle implication failed");

`else

`define DSKT_ASSERT(lbl, prop)
`define DSKT_IMPLIES(lbl, ante, cons)
`define DSKT_NEXT(lbl, ante, cons)

`endif

`endif

[src/dskt_pkg.sv]
// ----------------------------------------------------------------------------
// Descending sorted key table: package
// Field widths, stream packing, operation and status codes.
// ----------------------------------------------------------------------------
package dskt_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_TAG_BITS    = 32;

  localparam int ACT_W    = 3;
  localparam int KEY_W    = 64;
  localparam int TAG_IN_W = 32;
  localparam int POS_W    = 8;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 9;

  // stream packing
  localparam int IN_FIELDS_W  = KEY_W + TAG_IN_W + POS_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = POS_W + KEY_W + TAG_IN_W + CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_REKEY  = 3'd2,
    ACT_READ   = 3'd3,
    ACT_FIND   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

[src/dskt_ram.sv]
// ----------------------------------------------------------------------------
// Descending sorted key table: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dskt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[src/descending_sorted_key_table.sv]
// ----------------------------------------------------------------------------
// Descending sorted key table
// Key/tag pairs held in one RAM in descending signed key order.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: tuser is the action (insert, delete,
//   rekey, read, find), tdata holds key, tag and position. m_axis returns one
//   result item per command: tuser is the status, tdata holds position, key,
//   tag and the entry count after the command.
//   Commands are handled one at a time; s_axis_tready_o is high while idle.
//   Insert runs a binary search, shifts the tail and places the pair;
//   delete shifts the tail; rekey reads the entry to keep its tag, then
//   does a delete part plus an insert part; read fetches one entry; find
//   scans the tags from position 0; an error or unused action goes straight
//   to the result. The single RAM port pair sets the pace: each shift step
//   is one read and one write, each binary search probe a read then a
//   compare.
//   A finished result sits in the output register; a new command is taken
//   while it waits, and the block holds its next result until m_axis_tready_i.
//   Reset empties the table at once (count zero, no clearing pass).
// ----------------------------------------------------------------------------
`include "descending_sorted_key_table_macros.svh"

module descending_sorted_key_table
  import dskt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [63:0] key_in, [95:64] tag_in, [103:96] position_in
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [2:0] action
  input  logic [ACT_W-1:0]      s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] position_out, [71:8] key_out, [103:72] tag_out,
  // [112:104] entry_count, [119:113] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [STAT_W-1:0]     m_axis_tuser_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int MW = KEY_W + TAG_BITS;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SRCH     = 9'b000000010,
    S_SRCH_CMP = 9'b000000100,
    S_MOVE     = 9'b000001000,
    S_PLACE    = 9'b000010000,
    S_POS_RD   = 9'b000100000,
    S_POS_WAIT = 9'b001000000,
    S_FIND     = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [ACT_W-1:0]        act_q, act_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [TAG_BITS-1:0]     tag_q, tag_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [CW-1:0]           used_q, used_d;
  logic [CW-1:0]           lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           src_q, src_d, left_q, left_d;
  logic [AW-1:0]           dst_q, dst_d;
  logic                    up_q, up_d;
  logic                    pend_q, pend_d;
  logic                    ins_q, ins_d;
  status_e                 res_status_q, res_status_d;
  logic [POS_W-1:0]        res_pos_q, res_pos_d;
  logic [KEY_W-1:0]        res_key_q, res_key_d;
  logic [TAG_IN_W-1:0]     res_tag_q, res_tag_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]   out_data_q, out_data_d;
  logic [STAT_W-1:0]       out_user_q, out_user_d;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [MW-1:0]           ram_wdata, ram_rdata;
  logic [KEY_W-1:0]        rd_key;
  logic [TAG_BITS-1:0]     rd_tag;
  logic [CW:0]             mid_sum;
  logic [CW-1:0]           mid;

  logic [KEY_W-1:0]        in_key;
  logic [TAG_IN_W-1:0]     in_tag;
  logic [POS_W-1:0]        in_pos;
  logic                    in_accept;
  logic                    in_bad_pos;
  logic                    out_free;

  dskt_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign rd_key = ram_rdata[KEY_W-1:0];
  assign rd_tag = ram_rdata[MW-1:KEY_W];

  assign in_key = s_axis_tdata_i[KEY_W-1:0];
  assign in_tag = s_axis_tdata_i[KEY_W+TAG_IN_W-1:KEY_W];
  assign in_pos = s_axis_tdata_i[IN_FIELDS_W-1:KEY_W+TAG_IN_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign in_bad_pos      = PW'(in_pos) >= PW'(used_q);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // C-style midpoint over [lo, hi): floor((lo + hi - 1) / 2)
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
  assign mid     = mid_sum[CW:1];

  always_comb begin
    logic [CW-1:0] ins_idx;

    ins_idx      = lo_q;
    state_d      = state_q;
    act_d        = act_q;
    key_d        = key_q;
    tag_d        = tag_q;
    pos_d        = pos_q;
    used_d       = used_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    idx_d        = idx_q;
    src_d        = src_q;
    left_d       = left_q;
    dst_d        = dst_q;
    up_d         = up_q;
    pend_d       = pend_q;
    ins_d        = ins_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_key_d    = res_key_q;
    res_tag_d    = res_tag_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    ram_we       = 1'b0;
    ram_waddr    = dst_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = src_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          act_d        = s_axis_tuser_i;
          key_d        = in_key;
          tag_d        = TAG_BITS'(in_tag);
          pos_d        = in_pos;
          res_status_d = ST_OK;
          res_pos_d    = '0;
          res_key_d    = '0;
          res_tag_d    = '0;
          pend_d       = 1'b0;
          case (s_axis_tuser_i)
            ACT_INSERT: begin
              if (used_q == CW'(TABLE_DEPTH)) begin
                res_status_d = ST_FULL;
                state_d      = S_RESP;
              end else begin
                lo_d    = '0;
                hi_d    = used_q;
                state_d = S_SRCH;
              end
            end
            ACT_DELETE: begin
              if (in_bad_pos) begin
                res_status_d = ST_BAD_POS;
                state_d      = S_RESP;
              end else begin
                // close the gap: entries p+1 .. n-1 move down one address
                src_d   = CW'(in_pos) + CW'(1);
                left_d  = used_q - CW'(in_pos) - CW'(1);
                up_d    = 1'b0;
                ins_d   = 1'b0;
                state_d = S_MOVE;
              end
            end
            ACT_REKEY, ACT_READ: begin
              if (in_bad_pos) begin
                res_status_d = ST_BAD_POS;
                state_d      = S_RESP;
              end else begin
                state_d = S_POS_RD;
              end
            end
            ACT_FIND: begin
              src_d   = '0;
              state_d = S_FIND;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_POS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(pos_q);
        state_d   = S_POS_WAIT;
      end

      S_POS_WAIT: begin
        if (act_q == ACT_READ) begin
          res_key_d = rd_key;
          res_tag_d = TAG_IN_W'(rd_tag);
          res_pos_d = pos_q;
          state_d   = S_RESP;
        end else begin
          // rekey: keep the tag, then remove the entry
          tag_d   = rd_tag;
          src_d   = CW'(pos_q) + CW'(1);
          left_d  = used_q - CW'(pos_q) - CW'(1);
          up_d    = 1'b0;
          ins_d   = 1'b0;
          state_d = S_MOVE;
        end
      end

      S_SRCH, S_SRCH_CMP: begin
        logic go_move;
        go_move = 1'b0;
        if (state_q == S_SRCH) begin
          if (lo_q < hi_q) begin
            ram_re    = 1'b1;
            ram_raddr = mid[AW-1:0];
            mid_d     = mid;
            state_d   = S_SRCH_CMP;
          end else begin
            ins_idx = lo_q;
            go_move = 1'b1;
          end
        end else begin
          if (rd_key == key_q) begin
            // equal key: new pair goes in front of the hit
            ins_idx = mid_q;
            go_move = 1'b1;
          end else if ($signed(rd_key) > key_q) begin
            lo_d    = mid_q + CW'(1);
            state_d = S_SRCH;
          end else begin
            hi_d    = mid_q;
            state_d = S_SRCH;
          end
        end
        if (go_move) begin
          idx_d   = ins_idx;
          src_d   = used_q - CW'(1);
          left_d  = used_q - ins_idx;
          up_d    = 1'b1;
          ins_d   = 1'b1;
          state_d = S_MOVE;
        end
      end

      S_MOVE: begin
        // read at src, write it at dst in the next cycle
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
        end
        if (left_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = src_q[AW-1:0];
          pend_d    = 1'b1;
          dst_d     = up_q ? src_q[AW-1:0] + AW'(1) : src_q[AW-1:0] - AW'(1);
          src_d     = up_q ? src_q - CW'(1) : src_q + CW'(1);
          left_d    = left_q - CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (ins_q) begin
              state_d = S_PLACE;
            end else begin
              used_d = used_q - CW'(1);
              if (act_q == ACT_DELETE) begin
                res_pos_d = pos_q;
                state_d   = S_RESP;
              end else begin
                lo_d    = '0;
                hi_d    = used_q - CW'(1);
                state_d = S_SRCH;
              end
            end
          end
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = {tag_q, key_q};
        used_d    = used_q + CW'(1);
        res_pos_d = POS_W'(idx_q);
        state_d   = S_RESP;
      end

      S_FIND: begin
        if (pend_q && (rd_tag == tag_q)) begin
          res_pos_d = POS_W'(dst_q);
          pend_d    = 1'b0;
          state_d   = S_RESP;
        end else if (src_q < used_q) begin
          ram_re    = 1'b1;
          ram_raddr = src_q[AW-1:0];
          pend_d    = 1'b1;
          dst_d     = src_q[AW-1:0];
          src_d     = src_q + CW'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_user_d  = res_status_q;
          out_data_d  = {{OUT_PAD_W{1'b0}}, CNT_W'(used_q), res_tag_q, res_key_q, res_pos_q};
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    key_q        <= key_d;
    tag_q        <= tag_d;
    pos_q        <= pos_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    idx_q        <= idx_d;
    src_q        <= src_d;
    left_q       <= left_d;
    dst_q        <= dst_d;
    up_q         <= up_d;
    ins_q        <= ins_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_key_q    <= res_key_d;
    res_tag_q    <= res_tag_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // writes never land beyond the current end of the table
  `DSKT_IMPLIES(a_wr_in_table, ram_we, CW'(ram_waddr) <= used_q)
  // the entry count only moves while a command is being worked on
  `DSKT_NEXT(a_used_held_idle, state_q == S_IDLE, used_q == $past(used_q))
  // a read in flight belongs to a move or a tag scan
  `DSKT_IMPLIES(a_pend_ctx, pend_q, state_q == S_MOVE || state_q == S_FIND)

endmodule
